// ===== rtl/tzbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch zone button mapper package
// Shared widths, register codes, reset values, button bits and zone table.
// ----------------------------------------------------------------------------
`default_nettype none

package tzbm_pkg;

  localparam int POS_X_W = 11;
  localparam int POS_Y_W = 10;
  localparam int RAD_W   = 9;
  localparam int BTN_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Squared distances and squared radii.
  localparam int DIST2_W = 23;
  localparam int RAD2_W  = 2 * RAD_W;

  // Direction slope test: |other| * TAN_NUM < |axis| * TAN_DEN.
  localparam int TAN_NUM = 414;
  localparam int TAN_DEN = 1000;

  localparam int ZONE_COUNT_DEF = 9;
  localparam int FIXED_ZONES    = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_R  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_R   = 2'd3;

  localparam int RST_CENTER_X = 128;
  localparam int RST_CENTER_Y = 440;
  localparam int RST_OUTER_R  = 120;
  localparam int RST_DEAD_R   = 22;

  // Button bit positions.
  localparam int BTN_UP     = 0;
  localparam int BTN_DOWN   = 1;
  localparam int BTN_LEFT   = 2;
  localparam int BTN_RIGHT  = 3;
  localparam int BTN_EAST   = 4;
  localparam int BTN_SOUTH  = 5;
  localparam int BTN_NORTH  = 6;
  localparam int BTN_WEST   = 7;
  localparam int BTN_SELECT = 8;
  localparam int BTN_START  = 9;
  localparam int BTN_L1     = 10;
  localparam int BTN_R1     = 11;
  localparam int BTN_GUIDE  = 12;

  localparam int ZONE_CX [FIXED_ZONES] = '{1200, 1110, 1110, 1020, 1080, 1200, 128, 1090, 1236};
  localparam int ZONE_CY [FIXED_ZONES] = '{440, 530, 350, 440, 660, 660, 70, 70, 44};
  localparam int ZONE_RAD [FIXED_ZONES] = '{52, 52, 52, 52, 40, 40, 70, 60, 40};
  localparam int ZONE_BIT [FIXED_ZONES] = '{BTN_EAST, BTN_SOUTH, BTN_NORTH, BTN_WEST,
                                           BTN_SELECT, BTN_START, BTN_L1, BTN_R1, BTN_GUIDE};

  typedef struct packed {
    logic [POS_X_W-1:0] center_x;
    logic [POS_Y_W-1:0] center_y;
    logic [RAD2_W-1:0]  outer_r2;
    logic [RAD2_W-1:0]  dead_r2;
  } cfg_t;

  // Geometry stage results handed to the report stage.
  typedef struct packed {
    logic [DIST2_W-1:0] d2;
    logic [20:0]        ax_den;
    logic [19:0]        ax_num;
    logic [19:0]        ay_den;
    logic [18:0]        ay_num;
    logic               dx_pos;
    logic               dy_pos;
    logic [BTN_W-1:0]   zone_bits;
    logic               present;
    logic               last;
  } geom_t;

endpackage

`default_nettype wire

// ===== rtl/tzbm_cfg.sv =====
// ----------------------------------------------------------------------------
// Touch zone button mapper configuration registers
// Holds the d-pad center and keeps the radii already squared.
// ----------------------------------------------------------------------------
`default_nettype none

module tzbm_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tzbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tzbm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output tzbm_pkg::cfg_t                           cfg
);

  tzbm_pkg::cfg_t cfg_r;
  tzbm_pkg::cfg_t cfg_nxt;
  logic [tzbm_pkg::RAD_W-1:0]  rad;
  logic [tzbm_pkg::RAD2_W-1:0] rad2;

  assign cfg_ready = 1'b1;
  assign rad  = cfg_data[tzbm_pkg::RAD_W-1:0];
  assign rad2 = tzbm_pkg::RAD2_W'(rad) * tzbm_pkg::RAD2_W'(rad);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        tzbm_pkg::CFG_CENTER_X: cfg_nxt.center_x = cfg_data[tzbm_pkg::POS_X_W-1:0];
        tzbm_pkg::CFG_CENTER_Y: cfg_nxt.center_y = cfg_data[tzbm_pkg::POS_Y_W-1:0];
        tzbm_pkg::CFG_OUTER_R:  cfg_nxt.outer_r2 = rad2;
        tzbm_pkg::CFG_DEAD_R:   cfg_nxt.dead_r2  = rad2;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x <= tzbm_pkg::POS_X_W'(tzbm_pkg::RST_CENTER_X);
      cfg_r.center_y <= tzbm_pkg::POS_Y_W'(tzbm_pkg::RST_CENTER_Y);
      cfg_r.outer_r2 <= tzbm_pkg::RAD2_W'(tzbm_pkg::RST_OUTER_R * tzbm_pkg::RST_OUTER_R);
      cfg_r.dead_r2  <= tzbm_pkg::RAD2_W'(tzbm_pkg::RST_DEAD_R * tzbm_pkg::RST_DEAD_R);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/tzbm_geom.sv =====
// ----------------------------------------------------------------------------
// Touch zone button mapper geometry stage
// Squares, slope products and fixed zone hits, registered for the report stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tzbm_geom #(
  parameter int ZONE_COUNT = tzbm_pkg::ZONE_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            s1_valid,
  output logic                                 s1_ready,
  input  wire logic [tzbm_pkg::POS_X_W-1:0]    pos_x,
  input  wire logic [tzbm_pkg::POS_Y_W-1:0]    pos_y,
  input  wire logic                            present,
  input  wire logic                            report_end,
  input  wire tzbm_pkg::cfg_t                  cfg,
  output logic                                 s2_valid,
  input  wire logic                            s2_ready,
  output tzbm_pkg::geom_t                      s2
);

  localparam int ZONE_USED = (ZONE_COUNT < tzbm_pkg::FIXED_ZONES) ?
                             ZONE_COUNT : tzbm_pkg::FIXED_ZONES;

  logic                   s2_valid_r;
  tzbm_pkg::geom_t        s2_r;
  tzbm_pkg::geom_t        s2_nxt;

  logic [11:0] dx;
  logic [10:0] dy;
  logic [11:0] dx_mag;
  logic [10:0] dy_mag;
  logic [10:0] ax;
  logic [9:0]  ay;
  logic [21:0] ax2;
  logic [19:0] ay2;
  logic [ZONE_USED-1:0]        hit;
  logic [tzbm_pkg::BTN_W-1:0]  zone_bits;

  assign dx     = {1'b0, pos_x} - {1'b0, cfg.center_x};
  assign dy     = {1'b0, pos_y} - {1'b0, cfg.center_y};
  assign dx_mag = dx[11] ? (~dx + 12'd1) : dx;
  assign dy_mag = dy[10] ? (~dy + 11'd1) : dy;
  assign ax     = dx_mag[10:0];
  assign ay     = dy_mag[9:0];
  assign ax2    = 22'(ax) * 22'(ax);
  assign ay2    = 20'(ay) * 20'(ay);

  for (genvar g = 0; g < ZONE_USED; g++) begin : g_zone
    logic [11:0] zx;
    logic [10:0] zy;
    logic [11:0] zx_mag;
    logic [10:0] zy_mag;
    logic [21:0] zx2;
    logic [19:0] zy2;
    logic [tzbm_pkg::DIST2_W-1:0] z2;

    assign zx     = {1'b0, pos_x} - 12'(tzbm_pkg::ZONE_CX[g]);
    assign zy     = {1'b0, pos_y} - 11'(tzbm_pkg::ZONE_CY[g]);
    assign zx_mag = zx[11] ? (~zx + 12'd1) : zx;
    assign zy_mag = zy[10] ? (~zy + 11'd1) : zy;
    assign zx2    = 22'(zx_mag[10:0]) * 22'(zx_mag[10:0]);
    assign zy2    = 20'(zy_mag[9:0]) * 20'(zy_mag[9:0]);
    assign z2     = tzbm_pkg::DIST2_W'(zx2) + tzbm_pkg::DIST2_W'(zy2);
    assign hit[g] = (z2 <= tzbm_pkg::DIST2_W'(tzbm_pkg::ZONE_RAD[g] * tzbm_pkg::ZONE_RAD[g]));
  end

  always_comb begin
    zone_bits = '0;
    for (int i = 0; i < ZONE_USED; i++) begin
      zone_bits = zone_bits | ({tzbm_pkg::BTN_W{hit[i]}} &
                               (tzbm_pkg::BTN_W'(1) << tzbm_pkg::ZONE_BIT[i]));
    end
  end

  always_comb begin
    s2_nxt.d2        = tzbm_pkg::DIST2_W'(ax2) + tzbm_pkg::DIST2_W'(ay2);
    s2_nxt.ax_den    = 21'(ax) * 21'(tzbm_pkg::TAN_DEN);
    s2_nxt.ax_num    = 20'(ax) * 20'(tzbm_pkg::TAN_NUM);
    s2_nxt.ay_den    = 20'(ay) * 20'(tzbm_pkg::TAN_DEN);
    s2_nxt.ay_num    = 19'(ay) * 19'(tzbm_pkg::TAN_NUM);
    s2_nxt.dx_pos    = !dx[11] && (dx != 12'd0);
    s2_nxt.dy_pos    = !dy[10] && (dy != 11'd0);
    s2_nxt.zone_bits = zone_bits;
    s2_nxt.present   = present;
    s2_nxt.last      = report_end;
  end

  assign s1_ready = !s2_valid_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2       = s2_r;

endmodule

`default_nettype wire

// ===== rtl/tzbm_report.sv =====
// ----------------------------------------------------------------------------
// Touch zone button mapper report stage
// Builds the point mask, accumulates it over a report and emits changed masks.
// ----------------------------------------------------------------------------
`default_nettype none

module tzbm_report (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tzbm_pkg::cfg_t                  cfg,
  input  wire logic                            s2_valid,
  output logic                                 s2_ready,
  input  wire tzbm_pkg::geom_t                 s2,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [tzbm_pkg::BTN_W-1:0]           out_buttons
);

  logic [tzbm_pkg::BTN_W-1:0] accum_r;
  logic [tzbm_pkg::BTN_W-1:0] accum_nxt;
  logic [tzbm_pkg::BTN_W-1:0] reported_r;
  logic [tzbm_pkg::BTN_W-1:0] reported_nxt;
  logic [tzbm_pkg::BTN_W-1:0] out_buttons_r;
  logic [tzbm_pkg::BTN_W-1:0] out_buttons_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;

  logic                       in_ring;
  logic [tzbm_pkg::BTN_W-1:0] dir_bits;
  logic [tzbm_pkg::BTN_W-1:0] point_mask;
  logic [tzbm_pkg::BTN_W-1:0] acc_new;
  logic                       emit;
  logic                       take;

  assign in_ring = (s2.d2 <= tzbm_pkg::DIST2_W'(cfg.outer_r2)) &&
                   (s2.d2 >  tzbm_pkg::DIST2_W'(cfg.dead_r2));

  always_comb begin
    dir_bits = '0;
    if (21'(s2.ax_den) > 21'(s2.ay_num)) begin
      if (s2.dx_pos) begin
        dir_bits[tzbm_pkg::BTN_RIGHT] = 1'b1;
      end else begin
        dir_bits[tzbm_pkg::BTN_LEFT] = 1'b1;
      end
    end
    if (s2.ay_den > s2.ax_num) begin
      if (s2.dy_pos) begin
        dir_bits[tzbm_pkg::BTN_DOWN] = 1'b1;
      end else begin
        dir_bits[tzbm_pkg::BTN_UP] = 1'b1;
      end
    end
  end

  assign point_mask = (in_ring ? dir_bits : '0) | s2.zone_bits;
  assign acc_new    = s2.present ? (accum_r | point_mask) : accum_r;
  assign emit       = s2.last && (acc_new != reported_r);

  // An item that emits waits only while an earlier result is still unclaimed.
  assign s2_ready = !emit || !out_valid_r || out_ready;
  assign take     = s2_valid && s2_ready;

  always_comb begin
    accum_nxt       = accum_r;
    reported_nxt    = reported_r;
    out_buttons_nxt = out_buttons_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    if (take) begin
      accum_nxt = s2.last ? '0 : acc_new;
      if (emit) begin
        reported_nxt    = acc_new;
        out_buttons_nxt = acc_new;
        out_valid_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= '0;
      reported_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      accum_r     <= accum_nxt;
      reported_r  <= reported_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_buttons_r <= out_buttons_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_buttons = out_buttons_r;

  // A pending result always equals the mask last reported.
  a_out_matches_reported: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_buttons_r == reported_r))
    else $error("pending result differs from reported mask");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (take && emit) |=> (out_valid_r && (out_buttons_r == $past(acc_new))))
    else $error("emitted mask not presented");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && s2.last) |=> (accum_r == '0))
    else $error("accumulator not cleared at report end");

  a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid |-> (!(point_mask[tzbm_pkg::BTN_UP] && point_mask[tzbm_pkg::BTN_DOWN]) &&
                  !(point_mask[tzbm_pkg::BTN_LEFT] && point_mask[tzbm_pkg::BTN_RIGHT])))
    else $error("opposite directions from one point");

endmodule

`default_nettype wire

// ===== rtl/touch_zone_button_mapper_top.sv =====
// ----------------------------------------------------------------------------
// Touch zone button mapper
// Maps touch points to a 13-bit gamepad button mask and reports mask changes.
// ----------------------------------------------------------------------------
// Touch points enter on the in_ channel, one per transaction, each flagged
// present and report_end. Each present point is tested against the d-pad
// ring and nine fixed circular zones; the resulting bits are ORed over a
// report. On the item that ends a report, the accumulated mask goes out on
// the out_ channel only if it differs from the mask last sent.
// The pipeline has an input register, a geometry register (squares and slope
// products) and the output register; the item that ends a report passes
// through them in order. One item is taken per cycle while in_ready is high.
// The cfg_ channel writes the d-pad center and radii; it is always ready and
// is meant to be used while no item is in flight.
// Reset restores the default d-pad geometry and clears both the running mask
// and the last reported mask. While the receiver stalls, the result is held
// in the output register; items that emit nothing keep flowing, and in_ready
// drops only when a report end with a new mask reaches the held result.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_zone_button_mapper_top #(
  parameter int ZONE_COUNT = tzbm_pkg::ZONE_COUNT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [tzbm_pkg::POS_X_W-1:0]       in_pos_x,
  input  wire logic [tzbm_pkg::POS_Y_W-1:0]       in_pos_y,
  input  wire logic                               in_present,
  input  wire logic                               in_report_end,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [tzbm_pkg::BTN_W-1:0]              out_buttons,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tzbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tzbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic                          s1_valid_r;
  logic [tzbm_pkg::POS_X_W-1:0]  s1_pos_x_r;
  logic [tzbm_pkg::POS_Y_W-1:0]  s1_pos_y_r;
  logic                          s1_present_r;
  logic                          s1_last_r;
  logic                          s1_ready;
  logic                          s2_valid;
  logic                          s2_ready;
  tzbm_pkg::geom_t               s2;
  tzbm_pkg::cfg_t                cfg;

  tzbm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_ready = !s1_valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_pos_x_r   <= in_pos_x;
      s1_pos_y_r   <= in_pos_y;
      s1_present_r <= in_present;
      s1_last_r    <= in_report_end;
    end
  end

  tzbm_geom #(
    .ZONE_COUNT (ZONE_COUNT)
  ) u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .s1_ready   (s1_ready),
    .pos_x      (s1_pos_x_r),
    .pos_y      (s1_pos_y_r),
    .present    (s1_present_r),
    .report_end (s1_last_r),
    .cfg        (cfg),
    .s2_valid   (s2_valid),
    .s2_ready   (s2_ready),
    .s2         (s2)
  );

  tzbm_report u_report (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .s2_valid    (s2_valid),
    .s2_ready    (s2_ready),
    .s2          (s2),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_buttons (out_buttons)
  );

endmodule

`default_nettype wire
